// ===== rtl/mtr_pkg.sv =====
// ----------------------------------------------------------------------------
// mtr_pkg
// shared types, character constants and the attribute table of the rewriter
// ----------------------------------------------------------------------------
package mtr_pkg;

   localparam int MAX_NAME_LEN_DEF = 8;
   localparam int NAME_LEN_W       = 4;
   localparam int ATTR_LEN         = 24;
   localparam int POS_W            = 5;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_A     = 8'h61;

   typedef enum logic [2:0] {
      MODE_TEXT   = 3'd0,
      MODE_NAME   = 3'd1,
      MODE_IMG    = 3'd2,
      MODE_ANCHOR = 3'd3,
      MODE_QUOTE  = 3'd4
   } mode_type;

   // output work for one request: attribute prefix bytes, then up to two bytes
   typedef struct packed {
      logic [POS_W-1:0] flush_len;
      logic [1:0]       extra_cnt;
      logic [7:0]       byte0;
      logic [7:0]       byte1;
   } plan_type;

   // attribute that is deleted from anchor tags
   function automatic logic [7:0] attr_byte(input logic [POS_W-1:0] idx);
      logic [7:0] b;
      case (idx)
         5'd0:  b = 8'h64; // d
         5'd1:  b = 8'h61; // a
         5'd2:  b = 8'h74; // t
         5'd3:  b = 8'h61; // a
         5'd4:  b = 8'h2D; // -
         5'd5:  b = 8'h66; // f
         5'd6:  b = 8'h6C; // l
         5'd7:  b = 8'h69; // i
         5'd8:  b = 8'h63; // c
         5'd9:  b = 8'h6B; // k
         5'd10: b = 8'h72; // r
         5'd11: b = 8'h2D; // -
         5'd12: b = 8'h65; // e
         5'd13: b = 8'h6D; // m
         5'd14: b = 8'h62; // b
         5'd15: b = 8'h65; // e
         5'd16: b = 8'h64; // d
         5'd17: b = 8'h3D; // =
         5'd18: b = 8'h22; // quote
         5'd19: b = 8'h74; // t
         5'd20: b = 8'h72; // r
         5'd21: b = 8'h75; // u
         5'd22: b = 8'h65; // e
         5'd23: b = 8'h22; // quote
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // letters of the image tag name
   function automatic logic [7:0] img_char(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h69; // i
         2'd1:    b = 8'h6D; // m
         2'd2:    b = 8'h67; // g
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

endpackage

// ===== rtl/markup_tag_rewriter_core.sv =====
// the first result byte of a request, if it yields any, is shown the cycle after it is accepted
// throughput: one request per cycle while each request yields at most one byte and rsp_tready is high
// a request that yields more than one byte holds the input until its last byte is taken, as
// the single output register sends one byte per cycle while rsp_tready is high
// reset: synchronous, active high; returns to text mode and empties the output register
// ----------------------------------------------------------------------------
// markup_tag_rewriter_core
// streaming markup rewriter: closes img tags, strips a fixed anchor attribute
// ----------------------------------------------------------------------------
module markup_tag_rewriter_core #(
   parameter int MAX_NAME_LEN = mtr_pkg::MAX_NAME_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] data_byte
   input  logic       req_tuser,  // [0] end_mark
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] out_byte
   output logic       rsp_tlast
);
   import mtr_pkg::*;

   plan_type plan;
   logic     accept;
   logic     can_load;

   assign req_tready = can_load;
   assign accept     = req_tvalid && can_load;

   // state tracking and plan decode
   mtr_scanner #(
      .MAX_NAME_LEN(MAX_NAME_LEN)
   ) u_scanner (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .data_byte(req_tdata),
      .end_mark (req_tuser),
      .plan     (plan)
   );

   // result byte sequencing
   mtr_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .plan      (plan),
      .can_load  (can_load),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

// ===== rtl/mtr_scanner.sv =====
// ----------------------------------------------------------------------------
// mtr_scanner
// scan state of the rewriter and the output plan for each accepted request
// ----------------------------------------------------------------------------
module mtr_scanner #(
   parameter int MAX_NAME_LEN = mtr_pkg::MAX_NAME_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              end_mark,
   output mtr_pkg::plan_type plan
);
   import mtr_pkg::*;

   localparam logic [NAME_LEN_W-1:0] NameMax = NAME_LEN_W'(MAX_NAME_LEN);

   mode_type              mode_ff, mode_in;
   logic [NAME_LEN_W-1:0] len_ff, len_in;
   logic                  is_img_ff, is_img_in;
   logic                  is_anc_ff, is_anc_in;
   logic [7:0]            prev_ff, prev_in;
   logic [POS_W-1:0]      match_ff, match_in;
   logic [POS_W-1:0]      flush_cnt;
   logic                  attr_hit;

   // pending attribute prefix, capped at the attribute length
   assign flush_cnt = (match_ff > POS_W'(ATTR_LEN)) ? POS_W'(ATTR_LEN) : match_ff;
   assign attr_hit  = (match_ff < POS_W'(ATTR_LEN)) && (data_byte == attr_byte(match_ff));

   // next state and output plan
   always_comb begin
      mode_in        = mode_ff;
      len_in         = len_ff;
      is_img_in      = is_img_ff;
      is_anc_in      = is_anc_ff;
      prev_in        = prev_ff;
      match_in       = match_ff;
      plan.flush_len = '0;
      plan.extra_cnt = 2'd0;
      plan.byte0     = data_byte;
      plan.byte1     = CH_GT;
      if (end_mark) begin
         if (mode_ff == MODE_ANCHOR) begin
            plan.flush_len = flush_cnt;
         end
         match_in = '0;
         mode_in  = MODE_TEXT;
      end else begin
         case (mode_ff)
            MODE_NAME: begin
               plan.extra_cnt = 2'd1;
               if (is_letter(data_byte) && (len_ff < NameMax)) begin
                  if (!((len_ff < NAME_LEN_W'(3)) && (data_byte == img_char(len_ff[1:0])))) begin
                     is_img_in = 1'b0;
                  end
                  if (!((len_ff == '0) && (data_byte == CH_A))) begin
                     is_anc_in = 1'b0;
                  end
                  len_in = len_ff + NAME_LEN_W'(1);
               end else if ((len_ff == NAME_LEN_W'(3)) && is_img_ff) begin
                  prev_in = 8'h00;
                  mode_in = MODE_IMG;
               end else if ((len_ff == NAME_LEN_W'(1)) && is_anc_ff) begin
                  match_in = '0;
                  mode_in  = MODE_ANCHOR;
               end else begin
                  mode_in = MODE_TEXT;
               end
            end
            MODE_IMG: begin
               if (data_byte == CH_GT) begin
                  if (prev_ff != CH_SLASH) begin
                     plan.byte0     = CH_SLASH;
                     plan.extra_cnt = 2'd2;
                  end else begin
                     plan.extra_cnt = 2'd1;
                  end
                  mode_in = MODE_TEXT;
               end else begin
                  prev_in        = data_byte;
                  plan.extra_cnt = 2'd1;
               end
            end
            MODE_ANCHOR: begin
               if (data_byte == CH_GT) begin
                  plan.flush_len = flush_cnt;
                  plan.extra_cnt = 2'd1;
                  match_in       = '0;
                  mode_in        = MODE_TEXT;
               end else if (attr_hit) begin
                  // a complete copy is dropped
                  if (match_ff == POS_W'(ATTR_LEN - 1)) begin
                     match_in = '0;
                  end else begin
                     match_in = match_ff + POS_W'(1);
                  end
               end else begin
                  plan.flush_len = flush_cnt;
                  plan.extra_cnt = 2'd1;
                  match_in       = '0;
                  if (data_byte == CH_QUOTE) begin
                     mode_in = MODE_QUOTE;
                  end
               end
            end
            MODE_QUOTE: begin
               plan.extra_cnt = 2'd1;
               if (data_byte == CH_QUOTE) begin
                  mode_in = MODE_ANCHOR;
               end
            end
            default: begin
               plan.extra_cnt = 2'd1;
               if (data_byte == CH_LT) begin
                  len_in    = '0;
                  is_img_in = 1'b1;
                  is_anc_in = 1'b1;
                  mode_in   = MODE_NAME;
               end else begin
                  mode_in = MODE_TEXT;
               end
            end
         endcase
      end
   end

   // scan state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_TEXT;
         len_ff    <= '0;
         is_img_ff <= 1'b1;
         is_anc_ff <= 1'b1;
         prev_ff   <= 8'h00;
         match_ff  <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         len_ff    <= len_in;
         is_img_ff <= is_img_in;
         is_anc_ff <= is_anc_in;
         prev_ff   <= prev_in;
         match_ff  <= match_in;
      end
   end

endmodule

// ===== rtl/mtr_emitter.sv =====
// ----------------------------------------------------------------------------
// mtr_emitter
// output register holding one plan and sending its bytes one per cycle while rsp_tready is high
// ----------------------------------------------------------------------------
module mtr_emitter (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  mtr_pkg::plan_type plan,
   output logic              can_load,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast
);
   import mtr_pkg::*;

   plan_type         plan_ff;
   logic             valid_ff, valid_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] last_ff, last_in;
   logic             plan_busy;
   logic             done;

   // a plan with no bytes is never stored
   assign plan_busy = (plan.flush_len != '0) || (plan.extra_cnt != 2'd0);
   assign done      = valid_ff && rsp_tready && (pos_ff == last_ff);
   assign can_load  = !valid_ff || done;

   // byte select: attribute prefix, then the stored bytes
   always_comb begin
      if (pos_ff < plan_ff.flush_len) begin
         rsp_tdata = attr_byte(pos_ff);
      end else if (pos_ff == plan_ff.flush_len) begin
         rsp_tdata = plan_ff.byte0;
      end else begin
         rsp_tdata = plan_ff.byte1;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = (pos_ff == last_ff);

   // position and occupancy update
   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      last_in  = last_ff;
      if (done) begin
         valid_in = 1'b0;
      end else if (valid_ff && rsp_tready) begin
         pos_in = pos_ff + POS_W'(1);
      end
      if (load && plan_busy) begin
         valid_in = 1'b1;
         pos_in   = '0;
         last_in  = plan.flush_len + POS_W'(plan.extra_cnt) - POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
         last_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
         last_ff  <= last_in;
      end
   end

   // plan payload
   always_ff @(posedge clock) begin
      if (load && plan_busy) begin
         plan_ff <= plan;
      end
   end

endmodule

// ===== rtl/mtr_checker.sv =====
// ----------------------------------------------------------------------------
// mtr_checker
// port level checks of the rewriter, bound to the top level
// ----------------------------------------------------------------------------
module mtr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

   // output register is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // input only stalls while a result is pending
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no pending result");

   // no new request while a multi-byte run is still draining
   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !(rsp_tready && rsp_tlast)) |-> !req_tready)
      else $error("request accepted in the middle of a run");

   // an accepted result byte that is not the last of its run keeps the output busy
   a_busy_after_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("run ended without a last byte");

endmodule

bind markup_tag_rewriter_core mtr_checker u_mtr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);
